// ----- sv/clbd_pkg.sv -----
// Shared types and constants for the combined LCG bounded draw block.
// No dependencies; imported by every module of the block.
`default_nettype none

package clbd_pkg;

    localparam int STATE_W   = 31;            // generator state, registers, bound
    localparam int SEED_W    = 63;            // reseed value
    localparam int PROD_W    = 2 * STATE_W;   // exact product of two states
    localparam int DIVD_W    = SEED_W;        // widest dividend of the remainder unit
    localparam int NBITS_W   = $clog2(DIVD_W + 1);
    localparam int CNT_W     = $clog2(STATE_W);
    localparam int CFG_IDX_W = 2;
    localparam int MAX_TRIES = 64;
    localparam int TRY_W     = $clog2(MAX_TRIES);

    // dividend lengths for the remainder unit (dividend is left aligned)
    localparam logic [NBITS_W-1:0] NB_SEED  = NBITS_W'(SEED_W);
    localparam logic [NBITS_W-1:0] NB_PROD  = NBITS_W'(PROD_W);
    localparam logic [NBITS_W-1:0] NB_STATE = NBITS_W'(STATE_W);

    // operation codes
    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_B    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_B = 2'd3;

    // register reset values
    localparam logic [STATE_W-1:0] RST_MULT_A    = 31'd40014;
    localparam logic [STATE_W-1:0] RST_MODULUS_A = 31'd2147483563;
    localparam logic [STATE_W-1:0] RST_MULT_B    = 31'd40692;
    localparam logic [STATE_W-1:0] RST_MODULUS_B = 31'd2147483399;
    localparam logic [STATE_W-1:0] RST_STATE     = 31'd1;

    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIVD_W-1:0]  dividend;   // left aligned, MSB consumed first
        logic [NBITS_W-1:0] nbits;
        logic [STATE_W-1:0] divisor;
    } rem_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEEDX_GO, S_SEEDX_WAIT,
        S_SEEDY_GO, S_SEEDY_WAIT,
        S_LIM_GO,   S_LIM_WAIT,
        S_MULX_GO,  S_MULX_WAIT,
        S_MODX_GO,  S_MODX_WAIT,
        S_MULY_GO,  S_MULY_WAIT,
        S_MODY_GO,  S_MODY_WAIT,
        S_COMB,
        S_FIN_GO,   S_FIN_WAIT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/clbd_mul.sv -----
// Bit-serial shift-add multiplier, 31 x 31 -> 62 bits, one multiplier bit per cycle.
// Depends on clbd_pkg.
`default_nettype none

module clbd_mul (
    input  wire                        clk,
    input  wire                        rst_n,
    input  clbd_pkg::mul_req_t         req,
    output logic                       done,
    output logic [clbd_pkg::PROD_W-1:0] product
);
    import clbd_pkg::*;

    logic [STATE_W-1:0] hi_reg, lo_reg, a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [STATE_W:0]   sum;

    // add the multiplicand when the low bit of the multiplier is set, then shift right
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STATE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            hi_reg <= '0;
            lo_reg <= req.b;
            a_reg  <= req.a;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[STATE_W:1];
            lo_reg <= {sum[0], lo_reg[STATE_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ----- sv/clbd_rem.sv -----
// Bit-serial restoring remainder unit: up to 63-bit dividend by a 31-bit divisor,
// one dividend bit per cycle. A zero divisor gives remainder 0. Depends on clbd_pkg.
`default_nettype none

module clbd_rem (
    input  wire                          clk,
    input  wire                          rst_n,
    input  clbd_pkg::rem_req_t           req,
    output logic                         done,
    output logic [clbd_pkg::STATE_W-1:0] remainder
);
    import clbd_pkg::*;

    logic [DIVD_W-1:0]  div_reg;
    logic [STATE_W-1:0] rem_reg, d_reg;
    logic [NBITS_W-1:0] cnt_reg, last_reg;
    logic               busy_reg, done_reg;
    logic [STATE_W:0]   trial;
    logic [STATE_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, div_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                last_reg <= req.nbits - NBITS_W'(1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + NBITS_W'(1);
                if (cnt_reg == last_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.dividend;
            rem_reg <= '0;
            d_reg   <= req.divisor;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[STATE_W-1:0] : trial[STATE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = (d_reg == '0) ? '0 : rem_reg;

endmodule

`default_nettype wire

// ----- sv/combined_lcg_bounded_draw_top.sv -----
// Top level of the combined LCG bounded draw block: sequencer, state and registers.
// Depends on clbd_pkg, clbd_mul and clbd_rem.
`default_nettype none

// Combined random generator from two multiplicative congruential generators
// (x = a1*x mod m1, y = a2*y mod m2, both 31-bit, reset to 1). A reseed item
// (operation 0) sets x = 1 + seed mod (m1-1), y = 1 + seed mod (m2-1), then
// steps y once; it returns nothing. A draw item (operation 1) steps both,
// forms z = x - y (plus m1-1 when z <= 0), rejects z above
// bound*floor((m1-1)/bound) up to 64 tries, and returns z mod bound on value.
// All arithmetic goes through one bit-serial shift-add multiplier and one
// bit-serial restoring remainder unit, used one after the other by the
// sequencer. Each unit op has a launch state and a wait state for its done.
// A reseed reduces the seed for x, then for y, then multiplies and reduces
// y and returns to idle, where the next item is taken. A draw reduces the
// limit, then per try multiplies and reduces x, multiplies and reduces y and
// combines, each rejection repeating the try; it then makes the final
// reduction, and the next item is taken after the result is registered. A
// bound of 0 skips the limit step and returns 0. in_ready is high only while
// the sequencer is idle; the result sits in an output register, so a new
// item is taken while a value waits, and a draw stalls only when it
// finishes with a value still unread.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while the block is idle.

module combined_lcg_bounded_draw_top (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration
    input  wire                                cfg_we,
    input  wire  [clbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [clbd_pkg::STATE_W-1:0]       cfg_data,
    // input items
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                operation,
    input  wire  [clbd_pkg::SEED_W-1:0]        seed_value,
    input  wire  [clbd_pkg::STATE_W-1:0]       bound,
    // result items
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [clbd_pkg::STATE_W-1:0]       value
);
    import clbd_pkg::*;

    state_t state_reg, state_next;

    // configuration registers
    logic [STATE_W-1:0] mult_a_reg, modulus_a_reg, mult_b_reg, modulus_b_reg;

    // generator state and per-item context
    logic [STATE_W-1:0] x_reg, y_reg;
    logic               op_reg;
    logic [SEED_W-1:0]  seed_reg;
    logic [STATE_W-1:0] bound_reg, limit_reg, u_reg, res_reg;
    logic [TRY_W-1:0]   tries_reg;

    // output register
    logic               out_valid_reg;
    logic [STATE_W-1:0] value_reg;

    // shared arithmetic units
    mul_req_t           mul_req;
    rem_req_t           rem_req;
    logic               mul_done, rem_done;
    logic [PROD_W-1:0]  product;
    logic [STATE_W-1:0] remainder;

    logic [STATE_W-1:0] am1, bm1;
    logic signed [STATE_W+1:0] z_raw, z_adj;
    logic [STATE_W-1:0] u_comb;
    logic               try_ok;
    logic               slot_free;
    logic               accept;

    clbd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (product)
    );

    clbd_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (rem_req),
        .done      (rem_done),
        .remainder (remainder)
    );

    // modulus minus one, zero for a zero modulus
    assign am1 = (modulus_a_reg == '0) ? '0 : modulus_a_reg - STATE_W'(1);
    assign bm1 = (modulus_b_reg == '0) ? '0 : modulus_b_reg - STATE_W'(1);

    // combination step: z = x - y, fold non-positive by m1-1, clamp at zero
    always_comb
    begin
        z_raw = $signed({2'b00, x_reg}) - $signed({2'b00, y_reg});
        z_adj = z_raw;
        if (z_raw <= 0)
            z_adj = z_raw + $signed({2'b00, am1});
        if (z_adj < 0)
            z_adj = '0;
        u_comb = z_adj[STATE_W-1:0];
    end

    assign try_ok = (bound_reg == '0) || (u_comb <= limit_reg)
                    || (tries_reg == TRY_W'(MAX_TRIES - 1));

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_RESEED)
                        state_next = S_SEEDX_GO;
                    else if (bound != '0)
                        state_next = S_LIM_GO;
                    else
                        state_next = S_MULX_GO;
                end
            end
            S_SEEDX_GO:   state_next = S_SEEDX_WAIT;
            S_SEEDX_WAIT: if (rem_done) state_next = S_SEEDY_GO;
            S_SEEDY_GO:   state_next = S_SEEDY_WAIT;
            S_SEEDY_WAIT: if (rem_done) state_next = S_MULY_GO;
            S_LIM_GO:     state_next = S_LIM_WAIT;
            S_LIM_WAIT:   if (rem_done) state_next = S_MULX_GO;
            S_MULX_GO:    state_next = S_MULX_WAIT;
            S_MULX_WAIT:  if (mul_done) state_next = S_MODX_GO;
            S_MODX_GO:    state_next = S_MODX_WAIT;
            S_MODX_WAIT:  if (rem_done) state_next = S_MULY_GO;
            S_MULY_GO:    state_next = S_MULY_WAIT;
            S_MULY_WAIT:  if (mul_done) state_next = S_MODY_GO;
            S_MODY_GO:    state_next = S_MODY_WAIT;
            S_MODY_WAIT:
            begin
                if (rem_done)
                    state_next = (op_reg == OP_RESEED) ? S_IDLE : S_COMB;
            end
            S_COMB:       state_next = try_ok ? S_FIN_GO : S_MULX_GO;
            S_FIN_GO:     state_next = S_FIN_WAIT;
            S_FIN_WAIT:   if (rem_done) state_next = S_EMIT;
            S_EMIT:       if (slot_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // outputs: ready and unit requests
    always_comb
    begin
        in_ready = 1'b0;
        mul_req  = '0;
        rem_req  = '0;
        case (state_reg)
            S_IDLE:
                in_ready = 1'b1;
            S_SEEDX_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = seed_reg;
                rem_req.nbits    = NB_SEED;
                rem_req.divisor  = am1;
            end
            S_SEEDY_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = seed_reg;
                rem_req.nbits    = NB_SEED;
                rem_req.divisor  = bm1;
            end
            S_LIM_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = {am1, {(DIVD_W-STATE_W){1'b0}}};
                rem_req.nbits    = NB_STATE;
                rem_req.divisor  = bound_reg;
            end
            S_MULX_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = mult_a_reg;
                mul_req.b     = x_reg;
            end
            S_MODX_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = {product, {(DIVD_W-PROD_W){1'b0}}};
                rem_req.nbits    = NB_PROD;
                rem_req.divisor  = modulus_a_reg;
            end
            S_MULY_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = mult_b_reg;
                mul_req.b     = y_reg;
            end
            S_MODY_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = {product, {(DIVD_W-PROD_W){1'b0}}};
                rem_req.nbits    = NB_PROD;
                rem_req.divisor  = modulus_b_reg;
            end
            S_FIN_GO:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = {u_reg, {(DIVD_W-STATE_W){1'b0}}};
                rem_req.nbits    = NB_STATE;
                rem_req.divisor  = bound_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control state, configuration and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tries_reg     <= '0;
            mult_a_reg    <= RST_MULT_A;
            modulus_a_reg <= RST_MODULUS_A;
            mult_b_reg    <= RST_MULT_B;
            modulus_b_reg <= RST_MODULUS_B;
            x_reg         <= RST_STATE;
            y_reg         <= RST_STATE;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MULT_A:    mult_a_reg    <= cfg_data;
                    CFG_MODULUS_A: modulus_a_reg <= cfg_data;
                    CFG_MULT_B:    mult_b_reg    <= cfg_data;
                    CFG_MODULUS_B: modulus_b_reg <= cfg_data;
                    default:       mult_a_reg    <= mult_a_reg;
                endcase
            end

            if (accept)
                tries_reg <= '0;
            else if (state_reg == S_COMB)
                tries_reg <= tries_reg + TRY_W'(1);

            if (rem_done)
            begin
                case (state_reg)
                    S_SEEDX_WAIT: x_reg <= remainder + STATE_W'(1);
                    S_SEEDY_WAIT: y_reg <= remainder + STATE_W'(1);
                    S_MODX_WAIT:  x_reg <= remainder;
                    S_MODY_WAIT:  y_reg <= remainder;
                    default:      x_reg <= x_reg;
                endcase
            end

            if (state_reg == S_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item context and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            seed_reg  <= seed_value;
            bound_reg <= bound;
        end
        if (state_reg == S_LIM_WAIT && rem_done)
            limit_reg <= am1 - remainder;
        if (state_reg == S_COMB)
            u_reg <= u_comb;
        if (state_reg == S_FIN_WAIT && rem_done)
            res_reg <= remainder;
        if (state_reg == S_EMIT && slot_free)
            value_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

// ----- sv/clbd_checker.sv -----
// Port-level checker for the combined LCG bounded draw block, bound to the top level.
// Depends on clbd_pkg and combined_lcg_bounded_draw_top.
`default_nettype none

module clbd_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  wire                             in_ready,
    input  wire                             out_valid,
    input  wire                             out_ready,
    input  wire [clbd_pkg::STATE_W-1:0]     value
);
    import clbd_pkg::*;

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result changed or dropped while stalled");

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block ready again right after taking an item");

    // no result can appear in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too soon after an item");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind combined_lcg_bounded_draw_top clbd_checker u_clbd_checker (.*);

`default_nettype wire
